@@ src/swrp_pkg.sv @@
// Package for the sliding-window runs persistence block.
// Holds the fixed field widths, register indexes, reset values and ALU codes.
// No dependencies.
package swrp_pkg;

  // Fixed field widths
  localparam int IDX_W          = 17;
  localparam int CFG_W          = 17;
  localparam int WIN_CFG_W      = 9;
  localparam int REG_IDX_W      = 2;
  localparam int TOT_W          = 32;
  localparam int FLAG_BITS      = 5;
  localparam int OUT_FIXED_BITS = IDX_W + FLAG_BITS + 3 * TOT_W;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_FILL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERSIST  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_REVERT   = 2'd3;

  // Register reset values
  localparam logic [WIN_CFG_W-1:0] RST_WINDOW   = 9'd64;
  localparam logic [WIN_CFG_W-1:0] RST_MIN_FILL = 9'd16;
  localparam logic [IDX_W-1:0]     RST_PERSIST  = 17'd39322;
  localparam logic [IDX_W-1:0]     RST_REVERT   = 17'd19661;

  // Index reported when the window is not evaluated (0.5 in Q1.16)
  localparam logic [IDX_W-1:0] HALF_INDEX = 17'd32768;

  // Divider for 65536 / runs: one quotient bit per step
  localparam int DIV_STEPS = IDX_W;
  localparam int DIV_CNT_W = 5;

  // Shared adder operation codes
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic op;
    logic mul_en;
  } alu_ctl_t;

endpackage

@@ src/swrp_ring.sv @@
// Sample ring memory: one write port, one read port with registered data.
// Standalone, no package dependency.
module swrp_ring #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int ADR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ADR_W-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ADR_W-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the new sample, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/swrp_alu.sv @@
// Shared arithmetic unit: a registered sample-by-count multiplier and one
// add/subtract used for the window sum, the mean test and the divider.
// Depends on swrp_pkg.
module swrp_alu #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 9,
  localparam int AW         = SAMPLE_BITS + CNT_W + 1
) (
  input  logic                    clk,
  input  swrp_pkg::alu_ctl_t      ctl,
  input  logic signed [AW-1:0]    opa,
  input  logic signed [AW-1:0]    opb,
  input  logic signed [SAMPLE_BITS-1:0] mul_a,
  input  logic [CNT_W-1:0]        mul_b,
  output logic signed [AW-1:0]    prod,
  output logic signed [AW-1:0]    res,
  output logic                    ge
);
  import swrp_pkg::*;

  logic signed [AW-1:0] prod_r;

  // Register the product sample * n
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_a * $signed({1'b0, mul_b});
    end
  end

  // Add or subtract; ge is valid for subtraction
  always_comb begin
    if (ctl.op == ALU_SUB) begin
      res = opa - opb;
    end else begin
      res = opa + opb;
    end
    ge = ~res[AW-1];
  end

  assign prod = prod_r;

endmodule

@@ src/sliding_window_runs_persistence_core.sv @@
// Top level of the sliding-window runs persistence block.
// Uses swrp_pkg, swrp_ring (sample memory) and swrp_alu (shared arithmetic).
//
// Usage
//   Input stream: in_tuser carries cmd (1 = clear all state, 0 = record),
//   in_tdata carries the signed sample. Every accepted transaction yields
//   exactly one result transaction on the out_ stream.
//   Configuration: cfg_we writes register cfg_addr with cfg_wdata; write
//   only while the block is idle. Writing the window length empties the
//   ring.
//   Processing: a clear, or a record that leaves fewer than min_fill samples,
//   goes from idle straight to the result state. An evaluated record makes
//   one pass over the ring to sum it, one pass to count runs, both limited
//   by the single ring read port, then bit-serial division on the shared
//   adder.
//   in_tready is high only while the sequencer is idle, one item at a time.
//   The result sits in an output register; a new item may be accepted while
//   it waits, and the block holds its next result until out_tready frees it.
//   Reset (rst_n low, synchronous) clears all state and loads the register
//   defaults; ring contents need no clearing since reads stay within the
//   fill level.
module sliding_window_runs_persistence_core #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // Input stream
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata, // sample
  input  logic in_tuser,                                     // cmd
  // Result stream
  output logic out_tvalid,
  input  logic out_tready,
  // index_value, run_count, evaluated, persistent_now, reverting_now,
  // persistent_edge, reverting_edge, persistent_total, reverting_total,
  // record_total, zero padding
  output logic [((swrp_pkg::OUT_FIXED_BITS + $clog2(WINDOW_MAX + 1) + 7) / 8) * 8 - 1:0]
               out_tdata,
  // Configuration
  input  logic                            cfg_we,
  input  logic [swrp_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [swrp_pkg::CFG_W-1:0]      cfg_wdata
);
  import swrp_pkg::*;

  localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
  localparam int ADR_W    = $clog2(WINDOW_MAX);
  localparam int AW       = SAMPLE_BITS + CNT_W + 1;
  localparam int OUT_BITS = OUT_FIXED_BITS + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int EVAL_B   = IDX_W + CNT_W;
  localparam int TOT_LO   = EVAL_B + FLAG_BITS;
  localparam logic [CNT_W-1:0] WIN_MAX_C = CNT_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_RSETUP = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Configuration registers
  logic [WIN_CFG_W-1:0] win_len_r;
  logic [WIN_CFG_W-1:0] min_fill_r;
  logic [IDX_W-1:0]     p_thr_r;
  logic [IDX_W-1:0]     r_thr_r;

  // Block state
  logic [2:0]       state_r;
  logic [ADR_W-1:0] wp_r;
  logic [CNT_W-1:0] fill_r;
  logic             last_p_r;
  logic             last_r_r;
  logic [TOT_W-1:0] ped_r;
  logic [TOT_W-1:0] red_r;
  logic [TOT_W-1:0] recs_r;
  logic             eval_r;

  // Sequencer working registers
  logic [ADR_W-1:0]     base_r;
  logic [ADR_W-1:0]     ptr_r;
  logic [CNT_W-1:0]     iss_r;
  logic                 v1_r;
  logic                 v2_r;
  logic signed [AW-1:0] sum_r;
  logic [CNT_W-1:0]     runs_r;
  logic                 above_r;
  logic                 first_r;
  logic [CNT_W:0]       rem_r;
  logic [IDX_W-1:0]     q_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  // Output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // Combinational signals
  logic                   acc_fire;
  logic [CNT_W-1:0]       eff_win;
  logic [CNT_W-1:0]       wp_inc;
  logic [ADR_W-1:0]       wp_nxt;
  logic [CNT_W-1:0]       fill_nxt;
  logic                   eval_nxt;
  logic [CNT_W:0]         base_raw;
  logic [ADR_W-1:0]       base_nxt;
  logic [CNT_W-1:0]       ptr_inc;
  logic [ADR_W-1:0]       ptr_nxt;
  logic                   issue;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [CNT_W:0]         trial;
  alu_ctl_t               alu_ctl;
  logic signed [AW-1:0]   alu_a;
  logic signed [AW-1:0]   alu_b;
  logic signed [AW-1:0]   alu_prod;
  logic signed [AW-1:0]   alu_res;
  logic                   alu_ge;
  logic                   out_free;
  logic                   p_now;
  logic                   r_now;
  logic                   p_edge;
  logic                   r_edge;
  logic [TOT_W-1:0]       ped_nxt;
  logic [TOT_W-1:0]       red_nxt;
  logic [OUT_W-1:0]       out_word;

  assign acc_fire  = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = ~out_valid_r | out_tready;

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (win_len_r == '0) begin
      eff_win = CNT_ONE;
    end else if (32'(win_len_r) > 32'(WINDOW_MAX)) begin
      eff_win = WIN_MAX_C;
    end else begin
      eff_win = CNT_W'(win_len_r);
    end
  end

  // Advance write position and fill level for a record
  always_comb begin
    wp_inc   = CNT_W'(wp_r) + CNT_ONE;
    wp_nxt   = (wp_inc == eff_win) ? '0 : wp_inc[ADR_W-1:0];
    fill_nxt = (fill_r < eff_win) ? fill_r + CNT_ONE : eff_win;
    eval_nxt = (32'(fill_nxt) >= 32'(min_fill_r));
  end

  // Oldest entry of the window and ring pointer step
  always_comb begin
    base_raw = (CNT_W + 1)'(wp_r) + (CNT_W + 1)'(eff_win) - (CNT_W + 1)'(fill_r);
    if (base_raw >= (CNT_W + 1)'(eff_win)) begin
      base_raw = base_raw - (CNT_W + 1)'(eff_win);
    end
    base_nxt = base_raw[ADR_W-1:0];
    ptr_inc  = CNT_W'(ptr_r) + CNT_ONE;
    ptr_nxt  = (ptr_inc == eff_win) ? '0 : ptr_inc[ADR_W-1:0];
    issue    = ((state_r == S_SUM) || (state_r == S_RUN)) && (iss_r != fill_r);
    trial    = {rem_r[CNT_W-1:0], (dcnt_r == '0)};
  end

  swrp_ring #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (acc_fire & ~in_tuser),
    .waddr (wp_r),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .re    (issue),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  // Route operands to the shared unit by phase
  always_comb begin
    alu_ctl.op     = ALU_ADD;
    alu_ctl.mul_en = v1_r && (state_r == S_RUN);
    alu_a          = '0;
    alu_b          = '0;
    unique case (state_r)
      S_SUM: begin
        alu_a = sum_r;
        alu_b = AW'(rd_data);
      end
      S_RUN: begin
        alu_ctl.op = ALU_SUB;
        alu_a      = alu_prod;
        alu_b      = sum_r;
      end
      S_DIV: begin
        alu_ctl.op = ALU_SUB;
        alu_a      = $signed(AW'(trial));
        alu_b      = $signed(AW'(runs_r));
      end
      default: begin
        alu_ctl.op = ALU_ADD;
      end
    endcase
  end

  swrp_alu #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_alu (
    .clk   (clk),
    .ctl   (alu_ctl),
    .opa   (alu_a),
    .opb   (alu_b),
    .mul_a (rd_data),
    .mul_b (fill_r),
    .prod  (alu_prod),
    .res   (alu_res),
    .ge    (alu_ge)
  );

  // Flags, edges and result word
  always_comb begin
    p_now   = eval_r && (q_r > p_thr_r);
    r_now   = eval_r && (q_r < r_thr_r);
    p_edge  = p_now && !last_p_r;
    r_edge  = r_now && !last_r_r;
    ped_nxt = ped_r + TOT_W'(p_edge);
    red_nxt = red_r + TOT_W'(r_edge);
    out_word = '0;
    out_word[IDX_W-1:0]     = eval_r ? q_r : HALF_INDEX;
    out_word[IDX_W +: CNT_W] = eval_r ? runs_r : '0;
    out_word[EVAL_B]        = eval_r;
    out_word[EVAL_B + 1]    = p_now;
    out_word[EVAL_B + 2]    = r_now;
    out_word[EVAL_B + 3]    = p_edge;
    out_word[EVAL_B + 4]    = r_edge;
    out_word[TOT_LO +: TOT_W]             = ped_nxt;
    out_word[TOT_LO + TOT_W +: TOT_W]     = red_nxt;
    out_word[TOT_LO + 2 * TOT_W +: TOT_W] = recs_r;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= RST_WINDOW;
      min_fill_r <= RST_MIN_FILL;
      p_thr_r    <= RST_PERSIST;
      r_thr_r    <= RST_REVERT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW:   win_len_r  <= cfg_wdata[WIN_CFG_W-1:0];
        REG_MIN_FILL: min_fill_r <= cfg_wdata[WIN_CFG_W-1:0];
        REG_PERSIST:  p_thr_r    <= cfg_wdata;
        REG_REVERT:   r_thr_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      last_p_r    <= 1'b0;
      last_r_r    <= 1'b0;
      ped_r       <= '0;
      red_r       <= '0;
      recs_r      <= '0;
      eval_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Empty the ring on a window length write
      if (cfg_we && (cfg_addr == REG_WINDOW)) begin
        wp_r   <= '0;
        fill_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc_fire) begin
            state_r <= S_DONE;
            if (in_tuser) begin
              wp_r     <= '0;
              fill_r   <= '0;
              last_p_r <= 1'b0;
              last_r_r <= 1'b0;
              ped_r    <= '0;
              red_r    <= '0;
              recs_r   <= '0;
              eval_r   <= 1'b0;
            end else begin
              wp_r   <= wp_nxt;
              fill_r <= fill_nxt;
              recs_r <= recs_r + 1'b1;
              eval_r <= eval_nxt;
              if (eval_nxt) begin
                state_r <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          base_r  <= base_nxt;
          ptr_r   <= base_nxt;
          iss_r   <= '0;
          sum_r   <= '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          v1_r <= issue;
          if (issue) begin
            ptr_r <= ptr_nxt;
            iss_r <= iss_r + CNT_ONE;
          end
          if (v1_r) begin
            sum_r <= alu_res;
          end
          if (!issue && !v1_r) begin
            state_r <= S_RSETUP;
          end
        end
        S_RSETUP: begin
          ptr_r   <= base_r;
          iss_r   <= '0;
          first_r <= 1'b1;
          state_r <= S_RUN;
        end
        S_RUN: begin
          v1_r <= issue;
          v2_r <= v1_r;
          if (issue) begin
            ptr_r <= ptr_nxt;
            iss_r <= iss_r + CNT_ONE;
          end
          // Count class changes, oldest sample first
          if (v2_r) begin
            if (first_r) begin
              first_r <= 1'b0;
              above_r <= alu_ge;
              runs_r  <= CNT_ONE;
            end else if (alu_ge != above_r) begin
              above_r <= alu_ge;
              runs_r  <= runs_r + CNT_ONE;
            end
          end
          if (!issue && !v1_r && !v2_r) begin
            rem_r   <= '0;
            q_r     <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit of 65536 / runs per cycle
          rem_r  <= alu_ge ? alu_res[CNT_W:0] : trial;
          q_r    <= {q_r[IDX_W-2:0], alu_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (eval_r) begin
              last_p_r <= p_now;
              last_r_r <= r_now;
              ped_r    <= ped_nxt;
              red_r    <= red_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= out_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/swrp_checker.sv @@
// Port-level checks for the sliding-window runs persistence block, with the
// bind that attaches them to the top level. Depends on swrp_pkg.
module swrp_checker #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((swrp_pkg::OUT_FIXED_BITS + $clog2(WINDOW_MAX + 1) + 7) / 8) * 8 - 1:0]
              out_tdata,
  input logic cfg_we,
  input logic [swrp_pkg::REG_IDX_W-1:0] cfg_addr,
  input logic [swrp_pkg::CFG_W-1:0]     cfg_wdata
);
  import swrp_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int EVAL_B = IDX_W + CNT_W;
  localparam int PN_B   = EVAL_B + 1;
  localparam int RN_B   = EVAL_B + 2;
  localparam int PE_B   = EVAL_B + 3;
  localparam int RE_B   = EVAL_B + 4;

  // One item at a time: busy right after each accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item in progress");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Unevaluated results read 0.5 with no runs and no flags
  a_not_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[EVAL_B] |->
      out_tdata[IDX_W-1:0] == HALF_INDEX && out_tdata[IDX_W +: CNT_W] == '0 &&
      !out_tdata[PN_B] && !out_tdata[RN_B] && !out_tdata[PE_B] && !out_tdata[RE_B])
    else $error("unevaluated result carries index data");

  // An edge comes only with its flag set
  a_edge_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[PE_B] || out_tdata[PN_B]) &&
                   (!out_tdata[RE_B] || out_tdata[RN_B]))
    else $error("edge without its flag");

  // An evaluated window has at least one run
  a_eval_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[EVAL_B] |-> out_tdata[IDX_W +: CNT_W] != '0)
    else $error("evaluated result with zero runs");

endmodule

bind sliding_window_runs_persistence_core swrp_checker #(
  .WINDOW_MAX  (WINDOW_MAX),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swrp_checker (.*);

@@ test/swrp_window_monitor.sv @@
`timescale 1ns / 100ps
// Result predictor and monitor for sliding_window_runs_persistence_core.
// It watches the input, result and configuration ports, predicts every result and compares it.
// Depends on swrp_pkg for field widths, register indexes and reset values.
module swrp_window_monitor
  import swrp_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int IN_W        = 16,
  parameter int OUT_W       = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,    // sample
  input  logic                 in_tuser,    // cmd
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // index_value, run_count, evaluated, persistent_now, reverting_now,
  // persistent_edge, reverting_edge, persistent_total, reverting_total,
  // record_total, zero padding
  input  logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fault_count,
  output int                   outstanding
);

  localparam int RUN_W   = $clog2(WINDOW_MAX + 1);
  localparam int RUN_LO  = IDX_W;
  localparam int FLAG_LO = RUN_LO + RUN_W;
  localparam int PTOT_LO = FLAG_LO + FLAG_BITS;
  localparam int RTOT_LO = PTOT_LO + TOT_W;
  localparam int REC_LO  = RTOT_LO + TOT_W;

  typedef struct packed {
    logic [IDX_W-1:0] index_value;
    logic [RUN_W-1:0] run_count;
    logic             evaluated;
    logic             persistent_now;
    logic             reverting_now;
    logic             persistent_edge;
    logic             reverting_edge;
    logic [TOT_W-1:0] persistent_total;
    logic [TOT_W-1:0] reverting_total;
    logic [TOT_W-1:0] record_total;
  } runs_report_t;

  // Predicted copy of the block's state and registers
  logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
  int unsigned                   head;
  int unsigned                   depth;
  bit                            was_persistent;
  bit                            was_reverting;
  logic [TOT_W-1:0]              persist_rises;
  logic [TOT_W-1:0]              revert_rises;
  logic [TOT_W-1:0]              records;
  logic [WIN_CFG_W-1:0]          window_reg;
  logic [WIN_CFG_W-1:0]          min_fill_reg;
  logic [IDX_W-1:0]              persist_level;
  logic [IDX_W-1:0]              revert_level;

  runs_report_t awaited_reports [$];

  function automatic void wipe_history();
    foreach (history[i]) history[i] = '0;
    head  = 0;
    depth = 0;
  endfunction

  function automatic void wipe_state();
    wipe_history();
    was_persistent = 1'b0;
    was_reverting  = 1'b0;
    persist_rises  = '0;
    revert_rises   = '0;
    records        = '0;
  endfunction

  // Record or clear, then score the window with the exact runs test
  function automatic runs_report_t evaluate_window(logic clear_cmd,
                                                   logic signed [SAMPLE_BITS-1:0] smp);
    runs_report_t rep;
    int unsigned  span;
    int unsigned  n;
    int unsigned  base;
    int unsigned  runs;
    int unsigned  quotient;
    longint       total;
    longint       scale;
    bit           side;
    bit           prev_side;
    rep = '0;
    rep.index_value = HALF_INDEX;
    if (clear_cmd) begin
      wipe_state();
    end else begin
      // Out-of-range window lengths clamp to 1..WINDOW_MAX
      span = (window_reg == 0) ? 1 : (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
      head = head % span;
      history[head] = smp;
      head = (head + 1) % span;
      if (depth < span) depth++;
      if (depth >= min_fill_reg) begin
        n     = depth;
        base  = head + span - n;
        scale = n;
        total = 0;
        for (int i = 0; i < n; i++) total += history[(base + i) % span];
        // Count class changes, oldest sample first
        runs      = 1;
        prev_side = (history[base % span] * scale >= total);
        for (int i = 1; i < n; i++) begin
          side = (history[(base + i) % span] * scale >= total);
          if (side != prev_side) begin
            runs++;
            prev_side = side;
          end
        end
        quotient           = 65536 / runs;
        rep.evaluated      = 1'b1;
        rep.index_value    = quotient[IDX_W-1:0];
        rep.run_count      = runs[RUN_W-1:0];
        rep.persistent_now = (quotient > persist_level);
        rep.reverting_now  = (quotient < revert_level);
        if (rep.persistent_now && !was_persistent) begin
          rep.persistent_edge = 1'b1;
          persist_rises++;
        end
        if (rep.reverting_now && !was_reverting) begin
          rep.reverting_edge = 1'b1;
          revert_rises++;
        end
        was_persistent = rep.persistent_now;
        was_reverting  = rep.reverting_now;
      end
      records++;
    end
    rep.persistent_total = persist_rises;
    rep.reverting_total  = revert_rises;
    rep.record_total     = records;
    return rep;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // Track configuration, check each result transaction, then queue the next prediction
  always @(posedge clk) begin
    runs_report_t want;
    if (!rst_n) begin
      wipe_state();
      window_reg    = RST_WINDOW;
      min_fill_reg  = RST_MIN_FILL;
      persist_level = RST_PERSIST;
      revert_level  = RST_REVERT;
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW: begin
            window_reg = cfg_wdata[WIN_CFG_W-1:0];
            wipe_history();
          end
          REG_MIN_FILL: min_fill_reg  = cfg_wdata[WIN_CFG_W-1:0];
          REG_PERSIST:  persist_level = cfg_wdata;
          REG_REVERT:   revert_level  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (awaited_reports.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fault_count++;
        end else begin
          want = awaited_reports.pop_front();
          compare_field("index_value", want.index_value, out_tdata[IDX_W-1:0]);
          compare_field("run_count", want.run_count, out_tdata[RUN_LO +: RUN_W]);
          compare_field("evaluated", want.evaluated, out_tdata[FLAG_LO]);
          compare_field("persistent_now", want.persistent_now, out_tdata[FLAG_LO + 1]);
          compare_field("reverting_now", want.reverting_now, out_tdata[FLAG_LO + 2]);
          compare_field("persistent_edge", want.persistent_edge, out_tdata[FLAG_LO + 3]);
          compare_field("reverting_edge", want.reverting_edge, out_tdata[FLAG_LO + 4]);
          compare_field("persistent_total", want.persistent_total,
                        out_tdata[PTOT_LO +: TOT_W]);
          compare_field("reverting_total", want.reverting_total,
                        out_tdata[RTOT_LO +: TOT_W]);
          compare_field("record_total", want.record_total, out_tdata[REC_LO +: TOT_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_reports.push_back(evaluate_window(in_tuser, in_tdata[SAMPLE_BITS-1:0]));
      end
    end
    outstanding <= awaited_reports.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for sliding_window_runs_persistence_core.
// Drives samples, clears, register writes and back-pressure; swrp_window_monitor checks results.
// Depends on swrp_pkg, sliding_window_runs_persistence_core and swrp_window_monitor.
module testbench;
  import swrp_pkg::*;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((OUT_FIXED_BITS + $clog2(WINDOW_MAX + 1) + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 6000;

  typedef enum {PAT_WIDE, PAT_NOISY, PAT_DRIFT, PAT_SWING} pattern_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;     // sample
  logic                 in_tuser   = 1'b0;   // cmd
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // index_value, run_count, evaluated, persistent_now, reverting_now,
  // persistent_edge, reverting_edge, persistent_total, reverting_total,
  // record_total, zero padding
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr   = REG_WINDOW;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int fault_count;
  int outstanding;
  int sent         = 0;
  int stall_cycles = 0;
  int drift_level  = 0;
  bit steady       = 1'b0;
  bit hold_req     = 1'b0;
  bit swing_high   = 1'b0;

  always #2 clk = ~clk;

  sliding_window_runs_persistence_core #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  swrp_window_monitor #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL sliding_window_runs_persistence_core");
      $finish;
    end
  end

  // Result-side back-pressure; honour a requested long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  // Write one register, then drop the enable
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction, with random idle cycles ahead of it; valid stays high on return
  task automatic send_item(input logic cmd, input logic [IN_W-1:0] smp);
    while (!steady && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 17'd65536;
      2:       return $urandom_range(131071, 65537);
      default: return $urandom_range(65536);
    endcase
  endfunction

  // Shape the series so that runs are long, short or random
  function automatic logic [IN_W-1:0] next_sample(input pattern_t pattern);
    int v;
    if ($urandom_range(29) == 0) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    case (pattern)
      PAT_WIDE:  v = $urandom_range(65535);
      PAT_NOISY: v = drift_level + int'($urandom_range(512)) - 256;
      PAT_DRIFT: begin
        drift_level = drift_level + int'($urandom_range(64)) - 16;
        v = drift_level;
      end
      default: begin
        swing_high = !swing_high;
        v = swing_high ? drift_level + 300 + int'($urandom_range(200))
                       : drift_level - 300 - int'($urandom_range(200));
      end
    endcase
    return v[IN_W-1:0];
  endfunction

  initial begin
    logic [WIN_CFG_W-1:0] win;
    logic [WIN_CFG_W-1:0] minf;
    int                   span;
    int                   n_items;
    pattern_t             pattern;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: too few samples, field extremes, then a clear
    send_item(1'b0, 16'h7FFF);
    send_item(1'b0, 16'h8000);
    send_item(1'b0, 16'h0000);
    send_item(1'b1, 16'hFFFF);
    settle_block();

    // Zero window acts as one; zero min_fill; bottom and top-of-range thresholds
    write_reg(REG_WINDOW, 17'd0);
    write_reg(REG_MIN_FILL, 17'd0);
    write_reg(REG_PERSIST, 17'd0);
    write_reg(REG_REVERT, 17'd65536);
    send_item(1'b0, 16'h5555);
    send_item(1'b0, 16'hAAAA);
    settle_block();

    // Thresholds beyond 65536 used as they stand
    write_reg(REG_PERSIST, 17'h1FFFF);
    write_reg(REG_REVERT, 17'h1FFFF);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0001);
    settle_block();

    // Oversized window saturates; min_fill above it never evaluates, edge memory kept
    write_reg(REG_WINDOW, 17'h001FF);
    write_reg(REG_MIN_FILL, 17'd300);
    send_item(1'b0, 16'd100);
    send_item(1'b0, -16'sd100);
    settle_block();

    // Small window: alternating signs give many runs, a flat series gives one
    write_reg(REG_WINDOW, 17'd4);
    write_reg(REG_MIN_FILL, 17'd2);
    write_reg(REG_PERSIST, RST_PERSIST);
    write_reg(REG_REVERT, RST_REVERT);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0001);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0001);
    repeat (4) send_item(1'b0, 16'd5);
    send_item(1'b1, 16'h0000);
    send_item(1'b0, 16'd7);
    settle_block();

    // Full window with wrap-around, evaluated only near the top of the fill
    write_reg(REG_WINDOW, 17'd300);
    write_reg(REG_MIN_FILL, 17'd250);
    write_reg(REG_PERSIST, pick_threshold());
    write_reg(REG_REVERT, pick_threshold());
    drift_level = int'($urandom_range(65535)) - 32768;
    repeat (270) send_item(1'b0, next_sample(PAT_NOISY));

    // Random phases, mostly small windows
    while (sent < ITEM_TARGET) begin
      settle_block();
      case ($urandom_range(9))
        0:       win = $urandom_range(256, 65);
        1, 2:    win = $urandom_range(64, 17);
        3:       win = $urandom_range(511, 257);
        default: win = $urandom_range(16, 0);
      endcase
      span = (win == 0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
      minf = ($urandom_range(7) == 0) ? $urandom_range(511, span + 1) : $urandom_range(span);
      write_reg(REG_WINDOW, {8'd0, win});
      write_reg(REG_MIN_FILL, {8'd0, minf});
      write_reg(REG_PERSIST, pick_threshold());
      write_reg(REG_REVERT, pick_threshold());
      pattern     = pattern_t'($urandom_range(3));
      drift_level = int'($urandom_range(65535)) - 32768;
      n_items     = $urandom_range(70, 20);
      repeat (n_items) begin
        steady = (sent >= 600 && sent < 760);
        if (sent == 450 || sent == 1000) hold_req = 1'b1;
        send_item($urandom_range(32) == 0, next_sample(pattern));
      end
    end

    settle_block();
    repeat (16) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS sliding_window_runs_persistence_core");
    end else begin
      $display("FAIL sliding_window_runs_persistence_core");
    end
    $finish;
  end

endmodule
